// ===== rtl/mandelbrot_pixel_colour_unit_macros.svh =====
// assertion macros for the mandelbrot pixel colour unit
`ifndef MANDELBROT_PIXEL_COLOUR_UNIT_MACROS_SVH
`define MANDELBROT_PIXEL_COLOUR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MBPC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbpc assertion failed");

// next-cycle implication, checked out of reset
`define MBPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbpc assertion failed");

`endif

// ===== rtl/mbpc_pkg.sv =====
// shared types and constants for the mandelbrot pixel colour unit
package mbpc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int ITER_BITS_DEF  = 16;

  localparam int IMG_W       = 13;
  localparam int LIMIT_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int COLOR_W     = 8;
  localparam int COUNT_W     = 16;
  localparam int T_W         = 16;
  localparam int K_W         = 13;

  localparam logic [IMG_W-1:0]   RST_IMAGE_WIDTH    = 13'd1200;
  localparam logic [IMG_W-1:0]   RST_IMAGE_HEIGHT   = 13'd800;
  localparam logic [LIMIT_W-1:0] RST_MAX_ITERATIONS = 16'd500;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITERATIONS = 2'd2;

  // colour scale factors: 9*255, 15*255, 8.5*255*2
  localparam logic [K_W-1:0] K_RED   = 13'd2295;
  localparam logic [K_W-1:0] K_GREEN = 13'd3825;
  localparam logic [K_W-1:0] K_BLUE  = 13'd4335;

  typedef enum logic [1:0] {
    DIV_SEL_RE,
    DIV_SEL_IM,
    DIV_SEL_T
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_WAIT_RE,
    ST_MAP_IM,
    ST_WAIT_IM,
    ST_ITER_MUL,
    ST_ITER_UPD,
    ST_T_START,
    ST_T_WAIT,
    ST_COLOR1,
    ST_COLOR2,
    ST_COLOR3,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic     load_pixel;
    logic     div_start;
    div_sel_t div_sel;
    logic     store_re;
    logic     store_im;
    logic     store_t;
    logic     iter_clear;
    logic     iter_update;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic escape;
    logic at_limit;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/mbpc_div.sv =====
// restoring divider, one quotient bit per cycle
module mbpc_div #(
  parameter int DVD_W = 44,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [DVD_W-1:0] quot,
  output logic             rem_nz,
  output logic             done
);
  localparam int CW = $clog2(DVD_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DVD_W-1:0] sh;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] trial;

  assign rem_sh = {rem, sh[DVD_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      sh  <= dividend;
    end else if (busy) begin
      if (trial[DEN_W+1]) begin
        rem <= rem_sh[DEN_W-1:0];
        sh  <= {sh[DVD_W-2:0], 1'b0};
      end else begin
        rem <= trial[DEN_W-1:0];
        sh  <= {sh[DVD_W-2:0], 1'b1};
      end
    end
  end

  assign quot   = sh;
  assign rem_nz = |rem;

endmodule

// ===== rtl/mbpc_datapath.sv =====
// datapath: coordinate mapping, escape iteration and colour polynomials
module mbpc_datapath #(
  parameter int COORD_BITS = mbpc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mbpc_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS  = mbpc_pkg::ITER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mbpc_pkg::cmd_t                 cmd,
  output mbpc_pkg::sts_t                 sts,
  input  logic [mbpc_pkg::IMG_W-1:0]     image_width,
  input  logic [mbpc_pkg::IMG_W-1:0]     image_height,
  input  logic [mbpc_pkg::LIMIT_W-1:0]   iter_cap,
  input  logic [COORD_BITS-1:0]          pixel_x,
  input  logic [COORD_BITS-1:0]          pixel_y,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [mbpc_pkg::COLOR_W-1:0]   red,
  output logic [mbpc_pkg::COLOR_W-1:0]   green,
  output logic [mbpc_pkg::COLOR_W-1:0]   blue,
  output logic [mbpc_pkg::COUNT_W-1:0]   escape_count,
  output logic                           inside_set
);
  import mbpc_pkg::*;

  localparam int W         = FRAC_BITS + 4;
  localparam int NUM_W     = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
  localparam int DEN_W     = (ITER_BITS > 16) ? ITER_BITS : 16;
  localparam int MAP_DVD_W = NUM_W + FRAC_BITS;
  localparam int T_DVD_W   = ITER_BITS + T_W;
  localparam int DVD_W     = (MAP_DVD_W > T_DVD_W) ? MAP_DVD_W : T_DVD_W;
  localparam int TOT_W     = 77;

  localparam logic signed [W-1:0] FX_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] FX_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0]          FOUR   = (W+1)'(4) << FRAC_BITS;
  localparam logic [32:0]         IMAX   = (33'd1 << ITER_BITS) - 33'd1;

  function automatic logic signed [W-1:0] sat_prod(input logic [2*W-1:0] v);
    logic fits;
    fits = (&v[2*W-1:W-1]) || !(|v[2*W-1:W-1]);
    if (fits) sat_prod = v[W-1:0];
    else if (v[2*W-1]) sat_prod = FX_MIN;
    else sat_prod = FX_MAX;
  endfunction

  function automatic logic signed [W-1:0] sat_sum(input logic [W+1:0] v);
    logic fits;
    fits = (&v[W+1:W-1]) || !(|v[W+1:W-1]);
    if (fits) sat_sum = v[W-1:0];
    else if (v[W+1]) sat_sum = FX_MIN;
    else sat_sum = FX_MAX;
  endfunction

  function automatic logic signed [W-1:0] map_fix(input logic neg,
                                                  input logic [DVD_W-1:0] q,
                                                  input logic rnz);
    logic         over;
    logic [W-1:0] mag;
    over = |q[DVD_W-1:FRAC_BITS+3];
    mag  = {1'b0, q[FRAC_BITS+2:0]} + W'(rnz);
    if (over) map_fix = neg ? FX_MIN : FX_MAX;
    else if (neg) map_fix = W'(0) - mag;
    else map_fix = {1'b0, q[FRAC_BITS+2:0]};
  endfunction

  // pixel and coordinate mapping
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic [IMG_W-1:0]      dw;
  logic [IMG_W-1:0]      dh;
  logic [DEN_W-1:0]      dh5;
  logic [NUM_W-1:0]      x3;
  logic [NUM_W-1:0]      dw2;
  logic [NUM_W-1:0]      y12;
  logic [NUM_W-1:0]      dh6;
  logic                  neg_re;
  logic                  neg_im;
  logic [NUM_W-1:0]      mag_re;
  logic [NUM_W-1:0]      mag_im;

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      pix_x <= pixel_x;
      pix_y <= pixel_y;
    end
  end

  assign dw     = (image_width > IMG_W'(1)) ? image_width - IMG_W'(1) : IMG_W'(1);
  assign dh     = (image_height > IMG_W'(1)) ? image_height - IMG_W'(1) : IMG_W'(1);
  assign dh5    = DEN_W'({dh, 2'b00}) + DEN_W'(dh);
  assign x3     = NUM_W'(pix_x) * NUM_W'(3);
  assign dw2    = NUM_W'(dw) << 1;
  assign y12    = NUM_W'(pix_y) * NUM_W'(12);
  assign dh6    = NUM_W'(dh) * NUM_W'(6);
  assign neg_re = x3 < dw2;
  assign neg_im = y12 < dh6;
  assign mag_re = neg_re ? dw2 - x3 : x3 - dw2;
  assign mag_im = neg_im ? dh6 - y12 : y12 - dh6;

  // shared divider
  logic [DVD_W-1:0]     dvd;
  logic [DEN_W-1:0]     den;
  logic [DVD_W-1:0]     quot;
  logic                 rem_nz;
  logic [ITER_BITS-1:0] count;
  logic [ITER_BITS-1:0] lim;
  logic [32:0]          lim_wide;

  assign lim_wide = (33'(iter_cap) > IMAX) ? IMAX : 33'(iter_cap);
  assign lim      = lim_wide[ITER_BITS-1:0];

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SEL_RE: begin
        dvd = DVD_W'(mag_re) << FRAC_BITS;
        den = DEN_W'(dw);
      end
      DIV_SEL_IM: begin
        dvd = DVD_W'(mag_im) << FRAC_BITS;
        den = dh5;
      end
      DIV_SEL_T: begin
        dvd = DVD_W'(count) << T_W;
        den = DEN_W'(lim);
      end
      default: begin
        dvd = '0;
        den = '0;
      end
    endcase
  end

  mbpc_div #(
    .DVD_W(DVD_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (den),
    .quot     (quot),
    .rem_nz   (rem_nz),
    .done     (sts.div_done)
  );

  // escape iteration
  logic signed [W-1:0]   cr;
  logic signed [W-1:0]   ci;
  logic signed [W-1:0]   zr;
  logic signed [W-1:0]   zi;
  logic signed [W-1:0]   sq_r;
  logic signed [W-1:0]   sq_i;
  logic signed [W-1:0]   prod_ri;
  logic signed [2*W-1:0] prr;
  logic signed [2*W-1:0] pii;
  logic signed [2*W-1:0] pri;
  logic [W:0]            mag2;
  logic [W+1:0]          re_sum;
  logic [W+1:0]          im_sum;

  assign prr = zr * zr;
  assign pii = zi * zi;
  assign pri = zr * zi;

  always_ff @(posedge clk) begin
    sq_r    <= sat_prod(prr >>> FRAC_BITS);
    sq_i    <= sat_prod(pii >>> FRAC_BITS);
    prod_ri <= sat_prod(pri >>> (FRAC_BITS - 1));
  end

  assign mag2   = {1'b0, sq_r} + {1'b0, sq_i};
  assign re_sum = {{2{sq_r[W-1]}}, sq_r} - {{2{sq_i[W-1]}}, sq_i}
                + {{2{cr[W-1]}}, cr};
  assign im_sum = {{2{prod_ri[W-1]}}, prod_ri} + {{2{ci[W-1]}}, ci};

  assign sts.escape   = mag2 > FOUR;
  assign sts.at_limit = count >= lim;

  always_ff @(posedge clk) begin
    if (cmd.store_re) cr <= map_fix(neg_re, quot, rem_nz);
    if (cmd.store_im) ci <= map_fix(neg_im, quot, rem_nz);
    if (cmd.iter_clear) begin
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end else if (cmd.iter_update) begin
      zr    <= sat_sum(re_sum);
      zi    <= sat_sum(im_sum);
      count <= count + ITER_BITS'(1);
    end
  end

  // colour polynomials, three registered multiply levels
  logic [T_W-1:0]   t;
  logic [T_W:0]     u;
  logic [32:0]      ut_full;
  logic [31:0]      tt_full;
  logic [33:0]      uu_full;
  logic [30:0]      ut;
  logic [31:0]      tt;
  logic [32:0]      uu;
  logic [63:0]      pr_full;
  logic [63:0]      pg_full;
  logic [63:0]      pb_full;
  logic [62:0]      pr;
  logic [62:0]      pg;
  logic [62:0]      pb;
  logic [44:0]      rh;
  logic [44:0]      gh;
  logic [44:0]      bh;
  logic [43:0]      rl;
  logic [43:0]      gl;
  logic [43:0]      bl;
  logic [TOT_W-1:0] tot_r;
  logic [TOT_W-1:0] tot_g;
  logic [TOT_W-1:0] tot_b;

  always_ff @(posedge clk) begin
    if (cmd.store_t) t <= quot[T_W-1:0];
  end

  assign u       = (T_W+1)'(65536) - (T_W+1)'(t);
  assign ut_full = 33'(u) * 33'(t);
  assign tt_full = 32'(t) * 32'(t);
  assign uu_full = 34'(u) * 34'(u);
  assign pr_full = 64'(ut) * 64'(tt);
  assign pg_full = 64'(ut) * 64'(ut);
  assign pb_full = 64'(uu) * 64'(ut);

  always_ff @(posedge clk) begin
    ut <= ut_full[30:0];
    tt <= tt_full;
    uu <= uu_full[32:0];
    pr <= pr_full[62:0];
    pg <= pg_full[62:0];
    pb <= pb_full[62:0];
    rh <= 45'(pr[62:31]) * 45'(K_RED);
    rl <= 44'(pr[30:0]) * 44'(K_RED);
    gh <= 45'(pg[62:31]) * 45'(K_GREEN);
    gl <= 44'(pg[30:0]) * 44'(K_GREEN);
    bh <= 45'(pb[62:31]) * 45'(K_BLUE);
    bl <= 44'(pb[30:0]) * 44'(K_BLUE);
  end

  assign tot_r = (TOT_W'(rh) << 31) + TOT_W'(rl);
  assign tot_g = (TOT_W'(gh) << 31) + TOT_W'(gl);
  assign tot_b = (TOT_W'(bh) << 31) + TOT_W'(bl);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red          <= sts.at_limit ? '0 : tot_r[71:64];
      green        <= sts.at_limit ? '0 : tot_g[71:64];
      blue         <= sts.at_limit ? '0 : tot_b[72:65];
      escape_count <= COUNT_W'(count);
      inside_set   <= sts.at_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

endmodule

// ===== rtl/mbpc_ctrl.sv =====
// controller state machine sequencing one pixel through the datapath
module mbpc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mbpc_pkg::sts_t sts,
  output mbpc_pkg::cmd_t cmd
);
  import mbpc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_SEL_RE;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_pixel = 1'b1;
          state_next     = ST_MAP_RE;
        end
      end
      ST_MAP_RE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_RE;
        state_next    = ST_WAIT_RE;
      end
      ST_WAIT_RE: begin
        if (sts.div_done) begin
          cmd.store_re = 1'b1;
          state_next   = ST_MAP_IM;
        end
      end
      ST_MAP_IM: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_IM;
        state_next    = ST_WAIT_IM;
      end
      ST_WAIT_IM: begin
        if (sts.div_done) begin
          cmd.store_im   = 1'b1;
          cmd.iter_clear = 1'b1;
          state_next     = ST_ITER_MUL;
        end
      end
      ST_ITER_MUL: begin
        state_next = ST_ITER_UPD;
      end
      ST_ITER_UPD: begin
        priority if (sts.at_limit) begin
          state_next = ST_LOAD;
        end else if (sts.escape) begin
          state_next = ST_T_START;
        end else begin
          cmd.iter_update = 1'b1;
          state_next      = ST_ITER_MUL;
        end
      end
      ST_T_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_T;
        state_next    = ST_T_WAIT;
      end
      ST_T_WAIT: begin
        if (sts.div_done) begin
          cmd.store_t = 1'b1;
          state_next  = ST_COLOR1;
        end
      end
      ST_COLOR1: state_next = ST_COLOR2;
      ST_COLOR2: state_next = ST_COLOR3;
      ST_COLOR3: state_next = ST_LOAD;
      ST_LOAD: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/mandelbrot_pixel_colour_unit.sv =====
// top level of the mandelbrot pixel colour unit: config registers, controller, datapath
// an escaping pixel goes through the real and imaginary mapping divides, the iteration loop,
// the t divide and the colour stages before its result beat; a pixel inside the set skips the
// t divide and the colour stages and goes from the iteration loop straight to the load
// throughput: one pixel at a time; the time spent on a pixel is set by the shared bit-serial
// divider for its divides and by the multiply/update loop for each iteration
// reset: config goes to 1200 x 800 with limit 500, controller idles, no result pending
`include "mandelbrot_pixel_colour_unit_macros.svh"

module mandelbrot_pixel_colour_unit #(
  parameter int COORD_BITS = mbpc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mbpc_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS  = mbpc_pkg::ITER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [mbpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mbpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // pixel input beat
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [COORD_BITS-1:0]             pixel_x,
  input  logic [COORD_BITS-1:0]             pixel_y,
  // result beat
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mbpc_pkg::COLOR_W-1:0]      red,
  output logic [mbpc_pkg::COLOR_W-1:0]      green,
  output logic [mbpc_pkg::COLOR_W-1:0]      blue,
  output logic [mbpc_pkg::COUNT_W-1:0]      escape_count,
  output logic                              inside_set
);
  import mbpc_pkg::*;

  // config registers; written by the user only while no pixel in flight; not enforced
  logic [IMG_W-1:0]   image_width;
  logic [IMG_W-1:0]   image_height;
  logic [LIMIT_W-1:0] iter_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      iter_cap     <= RST_MAX_ITERATIONS;
    end else if (cfg_we) begin
      // indexes past the last register are dropped
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:    image_width  <= cfg_data[IMG_W-1:0];
        CFG_IMAGE_HEIGHT:   image_height <= cfg_data[IMG_W-1:0];
        CFG_MAX_ITERATIONS: iter_cap     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: map real, map imaginary, iterate, t divide and colour if escaped, load
  mbpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // the output register sits in the datapath, so a new pixel is taken
  // while the previous result still waits for out_ready
  mbpc_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .image_width  (image_width),
    .image_height (image_height),
    .iter_cap     (iter_cap),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .escape_count (escape_count),
    .inside_set   (inside_set)
  );

  // a result is never loaded over one that is still waiting
  `MBPC_ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, !(out_valid && !out_ready))
  // pixels inside the set come out black
  `MBPC_ASSERT_IMPLIES(a_inside_black, out_valid && inside_set, (red | green | blue) == '0)
  // once a pixel is taken the unit is busy with it
  `MBPC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule
